// ===== rtl/lpse_pkg.sv =====
// shared types, constants and symbol encoder for the led pixel spi encoder
package lpse_pkg;

	localparam int MAX_LEDS        = 256;
	localparam int IDX_W           = $clog2(MAX_LEDS);
	localparam int CNT_W           = IDX_W + 1;
	localparam int COLOR_W         = 24;
	localparam int SYM_W           = 5;
	localparam int BYTES_PER_PIXEL = 15;
	localparam int ENC_W           = COLOR_W * SYM_W;
	localparam int REM_W           = $clog2(BYTES_PER_PIXEL);
	localparam int QDEPTH          = 2;
	localparam int QPTR_W          = $clog2(QDEPTH);
	localparam int QCNT_W          = QPTR_W + 1;

	localparam logic [SYM_W-1:0] SYM_ZERO = 5'h18;
	localparam logic [SYM_W-1:0] SYM_ONE  = 5'h1C;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_FILL  = 2'd1,
		ACT_TICK  = 2'd2,
		ACT_EMIT  = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		MODE_OFF   = 2'd0,
		MODE_SOLID = 2'd1,
		MODE_BLINK = 2'd2,
		MODE_RSVD  = 2'd3
	} mode_t;

	typedef enum logic {
		CFG_CHAIN_LEN   = 1'b0,
		CFG_EFFECT_MODE = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		FR_IDLE = 1'b0,
		FR_READ = 1'b1
	} fr_state_t;

	typedef struct packed {
		logic [CNT_W-1:0] chain_len;
		logic [1:0]       effect_mode;
	} cfg_t;

	// one queued job for the back end
	typedef struct packed {
		logic               is_emit;
		logic               status;
		logic               frame_end;
		logic [COLOR_W-1:0] grb;
	} qent_t;

	// each color bit becomes 11000 or 11100, msb first
	function automatic logic [ENC_W-1:0] encode_grb(input logic [COLOR_W-1:0] grb);
		logic [ENC_W-1:0] enc;
		enc = '0;
		for (int k = 0; k < COLOR_W; k++) begin
			enc[k*SYM_W +: SYM_W] = grb[k] ? SYM_ONE : SYM_ZERO;
		end
		return enc;
	endfunction

endpackage

// ===== rtl/lpse_fifo.sv =====
// short request queue between the front and back ends
module lpse_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lpse_pkg::qent_t push_data,
	input  logic            pop,
	output lpse_pkg::qent_t head,
	output logic            full,
	output logic            empty
);
	import lpse_pkg::*;

	qent_t              qmem_q [QDEPTH];
	logic [QPTR_W-1:0]  wptr_q;
	logic [QPTR_W-1:0]  rptr_q;
	logic [QCNT_W-1:0]  cnt_q;

	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = qmem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= QPTR_W'(wptr_q + 1'b1);
			if (pop)  rptr_q <= QPTR_W'(rptr_q + 1'b1);
			if (push && !pop)      cnt_q <= QCNT_W'(cnt_q + 1'b1);
			else if (pop && !push) cnt_q <= QCNT_W'(cnt_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) qmem_q[wptr_q] <= push_data;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count out of range");

endmodule

// ===== rtl/lpse_front.sv =====
// front end: takes requests, owns the pixel store, cursor and blink state
module lpse_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lpse_pkg::cfg_t              cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  action,
	input  logic [lpse_pkg::IDX_W-1:0]  pixel_index,
	input  logic [7:0]                  red,
	input  logic [7:0]                  green,
	input  logic [7:0]                  blue,
	input  logic                        q_full,
	output logic                        push,
	output lpse_pkg::qent_t             push_data
);
	import lpse_pkg::*;

	fr_state_t            state_q, state_nxt;
	logic [COLOR_W-1:0]   mem_q [MAX_LEDS];
	logic [MAX_LEDS-1:0]  vld_q;
	logic [COLOR_W-1:0]   base_q;
	logic [COLOR_W-1:0]   blink_color_q;
	logic                 phase_q;
	logic [IDX_W-1:0]     cursor_q;
	logic [COLOR_W-1:0]   rd_s1;
	logic                 vld_s1;
	logic                 fe_s1;

	logic                 accept;
	act_t                 act;
	logic [COLOR_W-1:0]   color;
	logic [CNT_W-1:0]     n_eff;
	logic                 idx_bad;
	logic [IDX_W-1:0]     cur_eff;
	logic [CNT_W-1:0]     cur_inc;
	logic                 fe;
	logic                 blink_tick;

	assign act    = act_t'(action);
	assign color  = {green, red, blue};
	assign accept = in_valid && in_ready;

	always_comb begin
		if (cfg.chain_len == '0)                        n_eff = CNT_W'(1);
		else if (cfg.chain_len > CNT_W'(MAX_LEDS))      n_eff = CNT_W'(MAX_LEDS);
		else                                            n_eff = cfg.chain_len;
	end

	assign idx_bad    = ({1'b0, pixel_index} >= n_eff);
	// cursor left beyond a lowered count restarts the frame
	assign cur_eff    = ({1'b0, cursor_q} >= n_eff) ? '0 : cursor_q;
	assign cur_inc    = CNT_W'({1'b0, cur_eff} + 1'b1);
	assign fe         = (cur_inc == n_eff);
	assign blink_tick = (mode_t'(cfg.effect_mode) == MODE_BLINK);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			FR_IDLE: if (accept && act == ACT_EMIT) state_nxt = FR_READ;
			FR_READ: state_nxt = FR_IDLE;
			default: state_nxt = FR_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		push      = 1'b0;
		push_data = '0;
		unique case (state_q)
			FR_IDLE: begin
				in_ready = !q_full;
				push     = accept && act != ACT_EMIT;
				push_data.status = (act == ACT_WRITE) && idx_bad;
			end
			FR_READ: begin
				push                = 1'b1;
				push_data.is_emit   = 1'b1;
				push_data.frame_end = fe_s1;
				push_data.grb       = vld_s1 ? rd_s1 : base_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= FR_IDLE;
			vld_q         <= '0;
			base_q        <= '0;
			blink_color_q <= '0;
			phase_q       <= 1'b0;
			cursor_q      <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				unique case (act)
					ACT_WRITE: if (!idx_bad) vld_q[pixel_index] <= 1'b1;
					ACT_FILL: begin
						vld_q         <= '0;
						base_q        <= color;
						blink_color_q <= color;
						phase_q       <= 1'b0;
					end
					ACT_TICK: if (blink_tick) begin
						// whole store falls back to the new base color
						vld_q    <= '0;
						phase_q  <= !phase_q;
						base_q   <= phase_q ? blink_color_q : '0;
						cursor_q <= '0;
					end
					ACT_EMIT: cursor_q <= fe ? '0 : cur_inc[IDX_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && act == ACT_WRITE && !idx_bad) mem_q[pixel_index] <= color;
		rd_s1  <= mem_q[cur_eff];
		vld_s1 <= vld_q[cur_eff];
		fe_s1  <= fe;
	end

	a_emit_push: assert property (@(posedge clk) disable iff (!arst_n)
		accept && act == ACT_EMIT |=> push && push_data.is_emit)
		else $error("emit did not reach the queue");
	a_read_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FR_READ |-> !q_full)
		else $error("no queue room for emit");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == FR_IDLE)
		else $error("ready outside idle");

endmodule

// ===== rtl/lpse_back.sv =====
// back end: turns queued jobs into result bytes through an output register
module lpse_back (
	input  logic            clk,
	input  logic            arst_n,
	input  lpse_pkg::qent_t head,
	input  logic            q_empty,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      spi_byte,
	output logic            status,
	output logic            last,
	output logic            frame_end
);
	import lpse_pkg::*;

	logic                   out_valid_q;
	logic [REM_W-1:0]       rem_q;
	logic [ENC_W-9:0]       sr_q;
	logic                   fe_q;
	logic [7:0]             byte_q;
	logic                   status_q;
	logic                   last_q;
	logic                   frame_end_q;

	logic                   take;
	logic [ENC_W-1:0]       enc;

	assign take = !out_valid_q || out_ready;
	assign pop  = take && rem_q == '0 && !q_empty;
	assign enc  = encode_grb(head.grb);

	assign out_valid = out_valid_q;
	assign spi_byte  = byte_q;
	assign status    = status_q;
	assign last      = last_q;
	assign frame_end = frame_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rem_q       <= '0;
		end else if (take) begin
			if (rem_q != '0) begin
				out_valid_q <= 1'b1;
				rem_q       <= REM_W'(rem_q - 1'b1);
			end else if (!q_empty) begin
				out_valid_q <= 1'b1;
				rem_q       <= head.is_emit ? REM_W'(BYTES_PER_PIXEL - 1) : '0;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (rem_q != '0) begin
				byte_q      <= sr_q[ENC_W-9 -: 8];
				sr_q        <= {sr_q[ENC_W-17:0], 8'h00};
				status_q    <= 1'b0;
				last_q      <= (rem_q == REM_W'(1));
				frame_end_q <= fe_q && (rem_q == REM_W'(1));
			end else if (!q_empty) begin
				status_q    <= head.status;
				frame_end_q <= 1'b0;
				if (head.is_emit) begin
					byte_q <= enc[ENC_W-1 -: 8];
					sr_q   <= enc[ENC_W-9:0];
					fe_q   <= head.frame_end;
					last_q <= 1'b0;
				end else begin
					byte_q <= '0;
					last_q <= 1'b1;
				end
			end
		end
	end

	a_rem_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q != '0 |-> out_valid_q)
		else $error("bytes pending without a valid result");
	a_fe_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_end_q |-> last_q)
		else $error("frame end on a byte that is not last");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q != '0 |-> !pop)
		else $error("queue popped during a pixel");

endmodule

// ===== rtl/led_pixel_spi_encoder.sv =====
// top level of the led pixel spi encoder: config registers, front, queue, back
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  config   | cfg_we               | cfg_index, cfg_data
//  in       | in_valid / in_ready  | action, pixel_index, red, green, blue
//  out      | out_valid / out_ready| spi_byte, status, last, frame_end
//
// write, fill and tick requests each give one result
// an emit request reads the store and gives 15 bytes, one a cycle while out_ready is high
// the output byte register sets the sustained rate of emitted pixels
// reset clears the whole store to black at once through per-entry valid bits
// a stalled output holds the back end; the front keeps taking requests while the queue has room
module led_pixel_spi_encoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [lpse_pkg::CNT_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  action,
	input  logic [lpse_pkg::IDX_W-1:0]  pixel_index,
	input  logic [7:0]                  red,
	input  logic [7:0]                  green,
	input  logic [7:0]                  blue,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  spi_byte,
	output logic                        status,
	output logic                        last,
	output logic                        frame_end
);
	import lpse_pkg::*;

	cfg_t   cfg_q;
	logic   push;
	qent_t  push_data;
	logic   pop;
	qent_t  head;
	logic   q_full;
	logic   q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chain_len   <= CNT_W'(1);
			cfg_q.effect_mode <= MODE_OFF;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CHAIN_LEN:   cfg_q.chain_len   <= cfg_data;
				CFG_EFFECT_MODE: cfg_q.effect_mode <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	lpse_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.q_full      (q_full),
		.push        (push),
		.push_data   (push_data)
	);

	lpse_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	lpse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.spi_byte  (spi_byte),
		.status    (status),
		.last      (last),
		.frame_end (frame_end)
	);

endmodule

// ===== sim/led_pixel_spi_encoder_tb.sv =====
// testbench for the led pixel spi encoder: directed table, random requests, byte-level checks
`timescale 1ns / 100ps

module led_pixel_spi_encoder_tb;
	import lpse_pkg::*;

	localparam int      RANDOM_ITEMS    = 86;
	localparam int      SETTLE_CYCLES   = 6;
	localparam int      DRAIN_CYCLES    = 24;
	localparam int      HOLD_OFF_CYCLES = 400;
	localparam int      WATCHDOG_LIMIT  = 2000;
	// one 40-bit run of five bytes repeats three times per pixel
	localparam logic [39:0] BLACK_RUN = 40'hC6318C6318;
	localparam logic [39:0] WHITE_RUN = 40'hE739CE739C;

	typedef enum logic {
		ROW_REQ,
		ROW_CFG
	} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		act_t               act;
		logic [IDX_W-1:0]   idx;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic               typed;
		logic [39:0]        pattern;
		logic               st;
		logic               fe;
		cfg_idx_t           sel;
		logic [CNT_W-1:0]   value;
	} led_req_t;

	typedef struct packed {
		logic [7:0] spi_byte;
		logic       status;
		logic       last;
		logic       frame_end;
	} spi_result_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_index;
	logic [CNT_W-1:0]   cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         action;
	logic [IDX_W-1:0]   pixel_index;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic               out_valid;
	logic               out_ready;
	logic [7:0]         spi_byte;
	logic               status;
	logic               last;
	logic               frame_end;

	// predicted block state
	logic [COLOR_W-1:0] pixel_mem [MAX_LEDS];
	int                 cursor;
	logic               blink_on;
	logic [COLOR_W-1:0] blink_rgb;
	logic [CNT_W-1:0]   cfg_count;
	mode_t              cfg_mode;

	spi_result_t        spi_expected_q[$];
	int                 mismatches = 0;
	int                 bytes_checked = 0;
	int                 requests_sent;
	logic               rand_started;
	logic               held_off;

	led_pixel_spi_encoder i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.spi_byte    (spi_byte),
		.status      (status),
		.last        (last),
		.frame_end   (frame_end)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int led_span();
		int n;
		n = cfg_count;
		if (n == 0) n = 1;
		if (n > MAX_LEDS) n = MAX_LEDS;
		return n;
	endfunction

	function automatic logic [ENC_W-1:0] symbol_stream(input logic [COLOR_W-1:0] grb);
		logic [ENC_W-1:0] bits;
		bits = '0;
		for (int b = COLOR_W - 1; b >= 0; b--) begin
			bits = {bits[ENC_W-SYM_W-1:0], grb[b] ? SYM_ONE : SYM_ZERO};
		end
		return bits;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] rand_chan();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) return 8'h00;
		if (roll == 1) return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic led_req_t plain_req(input act_t a, input logic [IDX_W-1:0] i,
			input logic [23:0] rgb);
		led_req_t r;
		r.kind    = ROW_REQ;
		r.act     = a;
		r.idx     = i;
		r.red     = rgb[23:16];
		r.green   = rgb[15:8];
		r.blue    = rgb[7:0];
		r.typed   = 1'b0;
		r.pattern = '0;
		r.st      = 1'b0;
		r.fe      = 1'b0;
		r.sel     = CFG_CHAIN_LEN;
		r.value   = '0;
		return r;
	endfunction

	function automatic led_req_t fixed_req(input act_t a, input logic [IDX_W-1:0] i,
			input logic [23:0] rgb, input logic [39:0] pattern, input logic st, input logic fe);
		led_req_t r;
		r         = plain_req(a, i, rgb);
		r.typed   = 1'b1;
		r.pattern = pattern;
		r.st      = st;
		r.fe      = fe;
		return r;
	endfunction

	function automatic led_req_t cfg_row(input cfg_idx_t sel, input logic [CNT_W-1:0] value);
		led_req_t r;
		r       = plain_req(ACT_WRITE, '0, '0);
		r.kind  = ROW_CFG;
		r.sel   = sel;
		r.value = value;
		return r;
	endfunction

	function automatic led_req_t random_req();
		int   roll;
		act_t a;
		logic [IDX_W-1:0] i;
		roll = $urandom_range(0, 99);
		if (roll < 40) a = ACT_EMIT;
		else if (roll < 75) a = ACT_WRITE;
		else if (roll < 85) a = ACT_FILL;
		else a = ACT_TICK;
		// mostly in-range writes so emitted frames carry real content
		if ($urandom_range(0, 4) != 0) i = IDX_W'($urandom_range(0, led_span() - 1));
		else i = IDX_W'($urandom_range(0, MAX_LEDS - 1));
		return plain_req(a, i, {rand_chan(), rand_chan(), rand_chan()});
	endfunction

	function automatic logic [CNT_W-1:0] pick_count();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50) return CNT_W'($urandom_range(1, 6));
		if (roll < 65) return '0;
		if (roll < 75) return CNT_W'(MAX_LEDS);
		if (roll < 85) return CNT_W'($urandom_range(MAX_LEDS + 1, (1 << CNT_W) - 1));
		return CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
	endfunction

	task automatic fill_pixels(input logic [COLOR_W-1:0] grb);
		for (int k = 0; k < MAX_LEDS; k++) pixel_mem[k] = grb;
	endtask

	task automatic predict_request(input act_t a, input logic [IDX_W-1:0] i,
			input logic [COLOR_W-1:0] grb, ref spi_result_t fresh[$]);
		int               n;
		logic [ENC_W-1:0] bits;
		logic             fe;
		n = led_span();
		case (a)
			ACT_WRITE: begin
				if (i >= n) begin
					fresh.push_back('{8'h00, 1'b1, 1'b1, 1'b0});
				end else begin
					pixel_mem[i] = grb;
					fresh.push_back('{8'h00, 1'b0, 1'b1, 1'b0});
				end
			end
			ACT_FILL: begin
				fill_pixels(grb);
				blink_rgb = grb;
				blink_on  = 1'b0;
				fresh.push_back('{8'h00, 1'b0, 1'b1, 1'b0});
			end
			ACT_TICK: begin
				if (cfg_mode == MODE_BLINK) begin
					blink_on = ~blink_on;
					fill_pixels(blink_on ? '0 : blink_rgb);
					cursor = 0;
				end
				fresh.push_back('{8'h00, 1'b0, 1'b1, 1'b0});
			end
			default: begin
				// a lowered count can leave the cursor past the end
				if (cursor >= n) cursor = 0;
				bits = symbol_stream(pixel_mem[cursor]);
				fe   = (cursor + 1 == n);
				for (int k = 0; k < BYTES_PER_PIXEL; k++) begin
					fresh.push_back('{bits[ENC_W-1-8*k -: 8], 1'b0,
						k == BYTES_PER_PIXEL - 1, (k == BYTES_PER_PIXEL - 1) && fe});
				end
				cursor = fe ? 0 : cursor + 1;
			end
		endcase
	endtask

	task automatic send_request(input led_req_t r);
		spi_result_t fresh[$];
		int          gap;
		in_valid    <= 1'b1;
		action      <= r.act;
		pixel_index <= r.idx;
		red         <= r.red;
		green       <= r.green;
		blue        <= r.blue;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_request(r.act, r.idx, {r.green, r.red, r.blue}, fresh);
		if (r.typed) begin
			fresh.delete();
			if (r.act == ACT_EMIT) begin
				for (int k = 0; k < BYTES_PER_PIXEL; k++) begin
					fresh.push_back('{r.pattern[39-8*(k%5) -: 8], 1'b0,
						k == BYTES_PER_PIXEL - 1, (k == BYTES_PER_PIXEL - 1) && r.fe});
				end
			end else begin
				fresh.push_back('{8'h00, r.st, 1'b1, 1'b0});
			end
		end
		foreach (fresh[k]) spi_expected_q.push_back(fresh[k]);
		requests_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (spi_expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input cfg_idx_t sel, input logic [CNT_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= value;
		@(posedge clk);
		if (sel == CFG_CHAIN_LEN) cfg_count = value;
		else cfg_mode = mode_t'(value[1:0]);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// output checker
	always @(posedge clk) begin : result_check
		spi_result_t want;
		if (arst_n && out_valid && out_ready) begin
			bytes_checked++;
			if (spi_expected_q.size() == 0) begin
				$error("unexpected result: spi_byte %02h status %0b last %0b frame_end %0b",
					spi_byte, status, last, frame_end);
				mismatches++;
			end else begin
				want = spi_expected_q.pop_front();
				if (spi_byte !== want.spi_byte) begin
					$error("spi_byte: expected %02h, got %02h", want.spi_byte, spi_byte);
					mismatches++;
				end
				if (status !== want.status) begin
					$error("status: expected %0b, got %0b", want.status, status);
					mismatches++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					mismatches++;
				end
				if (frame_end !== want.frame_end) begin
					$error("frame_end: expected %0b, got %0b", want.frame_end, frame_end);
					mismatches++;
				end
			end
		end
	end

	// output side: random stalls plus one long hold-off once random traffic starts
	initial begin : receiver
		int gap;
		held_off  = 1'b0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rand_started && !held_off) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
		end
		$display("timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		led_req_t directed[$];
		int       random_sent;
		int       phases;
		int       missing;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_CHAIN_LEN;
		cfg_data      = '0;
		in_valid      = 1'b0;
		action        = ACT_WRITE;
		pixel_index   = '0;
		red           = '0;
		green         = '0;
		blue          = '0;
		requests_sent = 0;
		rand_started  = 1'b0;
		random_sent   = 0;
		phases        = 0;
		missing       = 0;
		fill_pixels('0);
		cursor    = 0;
		blink_on  = 1'b0;
		blink_rgb = '0;
		cfg_count = CNT_W'(1);
		cfg_mode  = MODE_OFF;

		// reset state: one black led, blink off
		directed.push_back(fixed_req(ACT_EMIT, 8'd0, 24'h000000, BLACK_RUN, 1'b0, 1'b1));
		directed.push_back(fixed_req(ACT_WRITE, 8'd0, 24'hFFFFFF, '0, 1'b0, 1'b0));
		directed.push_back(fixed_req(ACT_WRITE, 8'd1, 24'h123456, '0, 1'b1, 1'b0));
		directed.push_back(fixed_req(ACT_WRITE, 8'd255, 24'hFFFFFF, '0, 1'b1, 1'b0));
		directed.push_back(fixed_req(ACT_EMIT, 8'd0, 24'h000000, WHITE_RUN, 1'b0, 1'b1));
		directed.push_back(fixed_req(ACT_TICK, 8'd0, 24'h000000, '0, 1'b0, 1'b0));
		// zero count behaves as one led
		directed.push_back(cfg_row(CFG_CHAIN_LEN, '0));
		directed.push_back(fixed_req(ACT_EMIT, 8'd0, 24'h000000, WHITE_RUN, 1'b0, 1'b1));
		// oversized count clamps to the store depth
		directed.push_back(cfg_row(CFG_CHAIN_LEN, '1));
		directed.push_back(plain_req(ACT_WRITE, 8'd255, 24'h00FF00));
		directed.push_back(plain_req(ACT_WRITE, 8'd128, 24'h123456));
		directed.push_back(plain_req(ACT_EMIT, 8'd0, 24'h000000));
		directed.push_back(plain_req(ACT_FILL, 8'd0, 24'hA55A0F));
		directed.push_back(plain_req(ACT_EMIT, 8'd0, 24'h000000));
		directed.push_back(cfg_row(CFG_EFFECT_MODE, CNT_W'(MODE_BLINK)));
		directed.push_back(fixed_req(ACT_TICK, 8'd0, 24'h000000, '0, 1'b0, 1'b0));
		directed.push_back(fixed_req(ACT_EMIT, 8'd0, 24'h000000, BLACK_RUN, 1'b0, 1'b0));
		directed.push_back(plain_req(ACT_TICK, 8'd0, 24'h000000));
		directed.push_back(plain_req(ACT_EMIT, 8'd0, 24'h000000));
		directed.push_back(plain_req(ACT_EMIT, 8'd0, 24'h000000));
		// cursor now sits at the new count and must wrap
		directed.push_back(cfg_row(CFG_CHAIN_LEN, CNT_W'(2)));
		directed.push_back(plain_req(ACT_EMIT, 8'd0, 24'h000000));
		directed.push_back(plain_req(ACT_EMIT, 8'd0, 24'h000000));
		directed.push_back(cfg_row(CFG_EFFECT_MODE, CNT_W'(MODE_RSVD)));
		directed.push_back(plain_req(ACT_TICK, 8'd0, 24'h000000));
		directed.push_back(plain_req(ACT_EMIT, 8'd0, 24'h000000));
		directed.push_back(cfg_row(CFG_EFFECT_MODE, CNT_W'(MODE_SOLID)));
		directed.push_back(plain_req(ACT_TICK, 8'd0, 24'h000000));
		directed.push_back(plain_req(ACT_FILL, 8'd0, 24'h000000));
		directed.push_back(fixed_req(ACT_EMIT, 8'd0, 24'h000000, BLACK_RUN, 1'b0, 1'b1));
		directed.push_back(cfg_row(CFG_EFFECT_MODE, CNT_W'(MODE_OFF)));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[k]) begin
			if (directed[k].kind == ROW_CFG) begin
				wait_idle();
				write_cfg(directed[k].sel, directed[k].value);
			end else begin
				send_request(directed[k]);
			end
		end

		while (random_sent < RANDOM_ITEMS) begin
			wait_idle();
			if (phases == 0 || $urandom_range(0, 9) < 7) write_cfg(CFG_CHAIN_LEN, pick_count());
			if (phases == 0 || $urandom_range(0, 9) < 7) begin
				// upper data bits are don't-care for the mode register
				write_cfg(CFG_EFFECT_MODE,
					CNT_W'(($urandom_range(0, 127) << 2) | $urandom_range(0, 3)));
			end
			rand_started = 1'b1;
			phases++;
			repeat ($urandom_range(10, 25)) begin
				if (random_sent < RANDOM_ITEMS) begin
					send_request(random_req());
					random_sent++;
				end
			end
		end

		in_valid <= 1'b0;
		while (spi_expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (spi_expected_q.size() != 0) begin
			missing = spi_expected_q.size();
			$error("%0d expected results never arrived", missing);
		end

		$display("covered %0d requests (%0d random over %0d config phases), %0d bytes checked",
			requests_sent, random_sent, phases, bytes_checked);
		$display("%0d mismatches", mismatches + missing);
		if (mismatches + missing == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/lpse_pkg.sv
rtl/lpse_fifo.sv
rtl/lpse_front.sv
rtl/lpse_back.sv
rtl/led_pixel_spi_encoder.sv
sim/led_pixel_spi_encoder_tb.sv
